// ===== hdl/gbn_pkg.sv =====
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared types and constants for the go-back-N sender.
// ----------------------------------------------------------------------------
package gbn_pkg;

	localparam int QUEUE_DEPTH = 128;
	localparam int WINDOW_SIZE = 5;
	localparam int SEQ_WIDTH   = 32;
	localparam int SLOT_W      = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(WINDOW_SIZE + 1);

	localparam logic [1:0] CMD_MSG   = 2'd0;
	localparam logic [1:0] CMD_ACK   = 2'd1;
	localparam logic [1:0] CMD_TMO   = 2'd2;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_FULL    = 3'd1;
	localparam logic [2:0] ST_CORRUPT = 3'd2;
	localparam logic [2:0] ST_STALE   = 3'd3;
	localparam logic [2:0] ST_IDLE    = 3'd4;

	localparam logic [1:0] TMR_KEEP  = 2'd0;
	localparam logic [1:0] TMR_START = 2'd1;
	localparam logic [1:0] TMR_STOP  = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_DECIDE,
		S_READ,
		S_SEND,
		S_STATUS
	} state_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [31:0] seq_num;
		logic [31:0] ack_num;
		logic [15:0] check_in;
		logic [63:0] payload_a;
		logic [63:0] payload_b;
		logic [31:0] payload_c;
	} in_word_t;

	typedef struct packed {
		logic        kind;
		logic [31:0] out_seq;
		logic [31:0] out_ack;
		logic [15:0] out_check;
		logic [63:0] out_payload_a;
		logic [63:0] out_payload_b;
		logic [31:0] out_payload_c;
		logic [2:0]  status;
		logic [1:0]  timer_action;
		logic        last;
	} out_word_t;

	// One byte step of the CRC-style checksum.
	function automatic logic [15:0] crc_byte(input logic [15:0] r, input logic [7:0] b);
		logic [7:0] x;
		x = r[15:8] ^ b;
		x = x ^ {4'd0, x[7:4]};
		crc_byte = {r[7:0], 8'd0} ^ {x[3:0], 12'd0} ^ {3'd0, x, 5'd0} ^ {8'd0, x};
	endfunction

endpackage

// ===== hdl/gbn_if.sv =====
// ----------------------------------------------------------------------------
// gbn_if
// Valid/ready channels carrying input and result words.
// ----------------------------------------------------------------------------
interface gbn_in_if;
	logic             valid;
	logic             ready;
	gbn_pkg::in_word_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface gbn_out_if;
	logic              valid;
	logic              ready;
	gbn_pkg::out_word_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/go_back_n_sender_unit.sv =====
// ----------------------------------------------------------------------------
// go_back_n_sender_unit
// Go-back-N sender: packet queue in on-chip memory, window control, resend.
// ----------------------------------------------------------------------------
// One word is taken at a time. The checksum is computed two bytes per cycle
// over the twenty payload bytes, then every packet to send is read from the
// slot memory (registered read) and handed out, each read in its own state
// before it is sent, followed by the status word. The checksum loop and the
// single memory read port bound the pace; a receiver stall holds the block.
module go_back_n_sender_unit (
	input  logic clk,
	input  logic arst_n,
	gbn_in_if.sink     in_ch,
	gbn_out_if.source  out_ch
);

	localparam int SW = gbn_pkg::SEQ_WIDTH;
	localparam int SL = gbn_pkg::SLOT_W;
	localparam logic [SW-1:0] SEQ_ONE = SW'(1);

	gbn_pkg::state_t state_q, state_d;

	gbn_pkg::in_word_t in_q;
	logic [SW-1:0] base_q, new_q, unsent_q, send_q;
	logic [15:0]   crc_q;
	logic [3:0]    step_q;
	logic [gbn_pkg::CNT_W-1:0] cnt_q;
	logic [2:0]    status_q;
	logic [1:0]    timer_q;
	logic          resend_q;

	logic [159:0]  mem_pay [gbn_pkg::QUEUE_DEPTH];
	logic [15:0]   mem_chk [gbn_pkg::QUEUE_DEPTH];
	logic [159:0]  rd_pay_q;
	logic [15:0]   rd_chk_q;
	logic          wr_en;
	logic [SL-1:0] rd_slot;

	gbn_pkg::out_word_t out_q;
	logic          out_v_q;
	logic          out_load;

	logic [SW-1:0] used, ack_m, ack_off, uns_off, n_off;
	logic [159:0]  pay_all;
	logic [15:0]   crc_init, crc_next;
	logic [31:0]   seq_src, ack_src;
	logic          full;

	assign pay_all = {in_q.payload_c, in_q.payload_b, in_q.payload_a};
	assign used    = new_q - base_q;
	assign full    = (32'(used) >= 32'(gbn_pkg::QUEUE_DEPTH)) || (used == '1);
	assign ack_m   = in_q.ack_num[SW-1:0];
	assign ack_off = ack_m - base_q;
	assign uns_off = unsent_q - base_q;
	assign n_off   = new_q - base_q;
	assign seq_src = (in_q.command == gbn_pkg::CMD_MSG) ? 32'(new_q) : in_q.seq_num;
	assign ack_src = (in_q.command == gbn_pkg::CMD_MSG) ? 32'd1 : in_q.ack_num;

	always_comb begin
		logic [31:0] r;
		r = 32'hFFFF;
		for (int i = 0; i < 4; i++) begin
			r = r + (seq_src >> i) + (ack_src >> i);
		end
		crc_init = r[15:0];
	end

	always_comb begin
		logic [15:0] r;
		logic [4:0]  bi;
		bi = {step_q, 1'b0};
		r = gbn_pkg::crc_byte((step_q == 4'd0) ? crc_init : crc_q, pay_all[8*bi +: 8]);
		crc_next = gbn_pkg::crc_byte(r, pay_all[8*(bi+5'd1) +: 8]);
	end

	assign rd_slot = SL'(send_q % gbn_pkg::QUEUE_DEPTH);
	assign wr_en   = (state_q == gbn_pkg::S_DECIDE) && (in_q.command == gbn_pkg::CMD_MSG)
		&& !full;
	assign out_load = ((state_q == gbn_pkg::S_SEND) || (state_q == gbn_pkg::S_STATUS))
		&& (!out_v_q || out_ch.ready);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_pay[SL'(new_q % gbn_pkg::QUEUE_DEPTH)] <= pay_all;
			mem_chk[SL'(new_q % gbn_pkg::QUEUE_DEPTH)] <= crc_q;
		end
		rd_pay_q <= mem_pay[rd_slot];
		rd_chk_q <= mem_chk[rd_slot];
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			gbn_pkg::S_IDLE:   if (in_ch.valid) state_d = gbn_pkg::S_CHECK;
			gbn_pkg::S_CHECK:  if (step_q == 4'd9) state_d = gbn_pkg::S_DECIDE;
			gbn_pkg::S_DECIDE: state_d = gbn_pkg::S_READ;
			gbn_pkg::S_READ:   state_d = gbn_pkg::S_SEND;
			gbn_pkg::S_SEND:   if (!out_v_q || out_ch.ready) state_d = gbn_pkg::S_READ;
			gbn_pkg::S_STATUS: if (!out_v_q || out_ch.ready) state_d = gbn_pkg::S_IDLE;
			default:           state_d = gbn_pkg::S_IDLE;
		endcase
		if (state_q == gbn_pkg::S_READ && cnt_q == '0) state_d = gbn_pkg::S_STATUS;
	end

	assign in_ch.ready = (state_q == gbn_pkg::S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= gbn_pkg::S_IDLE;
			base_q   <= SEQ_ONE;
			new_q    <= SEQ_ONE;
			unsent_q <= SEQ_ONE;
			out_v_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) out_v_q <= 1'b1;
			else if (out_v_q && out_ch.ready) out_v_q <= 1'b0;
			unique case (state_q)
				gbn_pkg::S_IDLE: begin
					in_q   <= in_ch.data;
					step_q <= '0;
				end
				gbn_pkg::S_CHECK: begin
					crc_q  <= crc_next;
					step_q <= step_q + 4'd1;
				end
				gbn_pkg::S_DECIDE: begin
					status_q <= gbn_pkg::ST_OK;
					timer_q  <= gbn_pkg::TMR_KEEP;
					cnt_q    <= '0;
					resend_q <= 1'b0;
					send_q   <= unsent_q;
					unique case (in_q.command)
						gbn_pkg::CMD_MSG: begin
							if (full) status_q <= gbn_pkg::ST_FULL;
							else begin
								new_q <= new_q + SEQ_ONE;
								if (32'(uns_off) < 32'(gbn_pkg::WINDOW_SIZE)) begin
									cnt_q <= (n_off + SEQ_ONE - uns_off
										< SW'(gbn_pkg::WINDOW_SIZE) - uns_off)
										? gbn_pkg::CNT_W'(n_off + SEQ_ONE - uns_off)
										: gbn_pkg::CNT_W'(SW'(gbn_pkg::WINDOW_SIZE) - uns_off);
									if (uns_off == '0) timer_q <= gbn_pkg::TMR_START;
								end
							end
						end
						gbn_pkg::CMD_ACK: begin
							if (crc_q != in_q.check_in) status_q <= gbn_pkg::ST_CORRUPT;
							else if (ack_off >= uns_off) status_q <= gbn_pkg::ST_STALE;
							else begin
								base_q <= ack_m + SEQ_ONE;
								if (ack_m + SEQ_ONE == unsent_q) begin
									timer_q <= gbn_pkg::TMR_STOP;
									if (unsent_q != new_q) begin
										timer_q <= gbn_pkg::TMR_START;
										cnt_q <= (32'(new_q - unsent_q) < 32'(gbn_pkg::WINDOW_SIZE))
											? gbn_pkg::CNT_W'(new_q - unsent_q)
											: gbn_pkg::CNT_W'(gbn_pkg::WINDOW_SIZE);
									end
								end else timer_q <= gbn_pkg::TMR_START;
							end
						end
						gbn_pkg::CMD_TMO: begin
							if (uns_off == '0) status_q <= gbn_pkg::ST_IDLE;
							else begin
								timer_q  <= gbn_pkg::TMR_START;
								resend_q <= 1'b1;
								send_q   <= base_q;
								cnt_q <= (32'(uns_off) < 32'(gbn_pkg::WINDOW_SIZE))
									? gbn_pkg::CNT_W'(uns_off)
									: gbn_pkg::CNT_W'(gbn_pkg::WINDOW_SIZE);
							end
						end
						default: status_q <= gbn_pkg::ST_IDLE;
					endcase
				end
				gbn_pkg::S_READ: ;
				gbn_pkg::S_SEND: begin
					if (out_load) begin
						out_q   <= '{kind: 1'b0, out_seq: 32'(send_q), out_ack: 32'd1,
							out_check: rd_chk_q, out_payload_a: rd_pay_q[63:0],
							out_payload_b: rd_pay_q[127:64],
							out_payload_c: rd_pay_q[159:128],
							status: 3'd0, timer_action: 2'd0, last: 1'b0};
						send_q <= send_q + SEQ_ONE;
						cnt_q  <= cnt_q - gbn_pkg::CNT_W'(1);
						if (!resend_q) unsent_q <= unsent_q + SEQ_ONE;
					end
				end
				gbn_pkg::S_STATUS: begin
					if (out_load) begin
						out_q   <= '{kind: 1'b1, out_seq: 32'd0, out_ack: 32'd0,
							out_check: 16'd0, out_payload_a: 64'd0, out_payload_b: 64'd0,
							out_payload_c: 32'd0, status: status_q,
							timer_action: timer_q, last: 1'b1};
					end
				end
				default: ;
			endcase
		end
	end

	assign out_ch.valid = out_v_q;
	assign out_ch.data  = out_q;

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> state_q == gbn_pkg::S_IDLE) else $error("ready outside idle");
	a_win: assert property (@(posedge clk) disable iff (!arst_n)
		32'(unsent_q - base_q) <= 32'(gbn_pkg::WINDOW_SIZE)) else $error("window overrun");
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		(unsent_q - base_q) <= (new_q - base_q)) else $error("unsent past new");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !out_ch.ready |=> out_v_q) else $error("word lost");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for go_back_n_sender_unit. A scoreboard class predicts
// the packet and status words of every accepted command word (message, ack,
// timer expiry) and checks each result word in order. Stimulus is a short
// directed run, a queue-filling burst under a long receiver hold-off, then
// a random mix of messages, good, corrupt and stale acks and expiries, with
// random gaps on both channels.
// ----------------------------------------------------------------------------
module tb;

	localparam logic [1:0] CMD_NONE = 2'd3;

	class gbn_scoreboard;
		bit [31:0] base, nxt_new, nxt_unsent;
		bit [63:0] store_a [gbn_pkg::QUEUE_DEPTH];
		bit [63:0] store_b [gbn_pkg::QUEUE_DEPTH];
		bit [31:0] store_c [gbn_pkg::QUEUE_DEPTH];
		bit [15:0] store_ck [gbn_pkg::QUEUE_DEPTH];
		gbn_pkg::out_word_t expq [$];
		int mismatches;

		function new();
			base = 1;
			nxt_new = 1;
			nxt_unsent = 1;
			mismatches = 0;
		endfunction

		function bit [15:0] checksum(bit [31:0] s, bit [31:0] a, bit [63:0] x0,
				bit [63:0] x1, bit [31:0] x2);
			bit [31:0] r, x;
			bit [159:0] bytes;
			r = 32'hFFFF;
			bytes = {x2, x1, x0};
			for (int i = 0; i < 4; i++) begin
				r = r + (s >> i);
				r = r + (a >> i);
			end
			for (int i = 0; i < 20; i++) begin
				x = ((r >> 8) ^ bytes[8*i +: 8]) & 32'hFF;
				x = x ^ (x >> 4);
				r = ((r << 8) ^ (x << 12) ^ (x << 5) ^ x) & 32'hFFFF;
			end
			return r[15:0];
		endfunction

		function int outstanding();
			return int'(nxt_unsent - base);
		endfunction

		function void push_packet(bit [31:0] s);
			gbn_pkg::out_word_t o;
			int slot;
			slot = s % gbn_pkg::QUEUE_DEPTH;
			o = '0;
			o.out_seq = s;
			o.out_ack = 32'd1;
			o.out_check = store_ck[slot];
			o.out_payload_a = store_a[slot];
			o.out_payload_b = store_b[slot];
			o.out_payload_c = store_c[slot];
			expq.push_back(o);
		endfunction

		function void send_waiting(inout bit [1:0] tmr);
			while ((nxt_unsent - base) < (nxt_new - base) &&
				(nxt_unsent - base) < gbn_pkg::WINDOW_SIZE) begin
				push_packet(nxt_unsent);
				if (nxt_unsent == base)
					tmr = gbn_pkg::TMR_START;
				nxt_unsent = nxt_unsent + 1;
			end
		endfunction

		function void note_input(gbn_pkg::in_word_t w);
			gbn_pkg::out_word_t o;
			bit [2:0] st;
			bit [1:0] tmr;
			int slot, n;
			st = gbn_pkg::ST_OK;
			tmr = gbn_pkg::TMR_KEEP;
			case (w.command)
				gbn_pkg::CMD_MSG: begin
					if ((nxt_new - base) >= gbn_pkg::QUEUE_DEPTH ||
						(nxt_new - base) >= 32'hFFFF_FFFF)
						st = gbn_pkg::ST_FULL;
					else begin
						slot = nxt_new % gbn_pkg::QUEUE_DEPTH;
						store_a[slot] = w.payload_a;
						store_b[slot] = w.payload_b;
						store_c[slot] = w.payload_c;
						store_ck[slot] = checksum(nxt_new, 32'd1, w.payload_a,
							w.payload_b, w.payload_c);
						nxt_new = nxt_new + 1;
						send_waiting(tmr);
					end
				end
				gbn_pkg::CMD_ACK: begin
					if (w.check_in != checksum(w.seq_num, w.ack_num, w.payload_a,
							w.payload_b, w.payload_c))
						st = gbn_pkg::ST_CORRUPT;
					else if ((w.ack_num - base) >= (nxt_unsent - base))
						st = gbn_pkg::ST_STALE;
					else begin
						base = w.ack_num + 1;
						if (base == nxt_unsent) begin
							tmr = gbn_pkg::TMR_STOP;
							send_waiting(tmr);
						end else
							tmr = gbn_pkg::TMR_START;
					end
				end
				gbn_pkg::CMD_TMO: begin
					n = outstanding();
					if (n == 0)
						st = gbn_pkg::ST_IDLE;
					else begin
						for (int i = 0; i < n && i < gbn_pkg::WINDOW_SIZE; i++)
							push_packet(base + i);
						tmr = gbn_pkg::TMR_START;
					end
				end
				default: st = gbn_pkg::ST_IDLE;
			endcase
			o = '0;
			o.kind = 1'b1;
			o.status = st;
			o.timer_action = tmr;
			o.last = 1'b1;
			expq.push_back(o);
		endfunction

		function void check(gbn_pkg::out_word_t got);
			gbn_pkg::out_word_t exp_w;
			if (expq.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word %p", got);
				return;
			end
			exp_w = expq.pop_front();
			if (got !== exp_w) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result mismatch\n  expected %p\n  actual   %p", exp_w, got);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	gbn_in_if in_ch ();
	gbn_out_if out_ch ();
	gbn_scoreboard board;
	bit hold_req;
	bit no_gaps;
	int sent_items;

	go_back_n_sender_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always #6 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 45)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_word(gbn_pkg::in_word_t w);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= w;
		do @(posedge clk); while (!in_ch.ready);
		board.note_input(w);
		sent_items++;
	endtask

	function automatic gbn_pkg::in_word_t rand_word(logic [1:0] cmd);
		gbn_pkg::in_word_t w;
		w.command = cmd;
		w.seq_num = $urandom;
		w.ack_num = $urandom;
		w.check_in = 16'($urandom);
		w.payload_a = {$urandom, $urandom};
		w.payload_b = {$urandom, $urandom};
		w.payload_c = $urandom;
		return w;
	endfunction

	task automatic send_msg();
		send_word(rand_word(gbn_pkg::CMD_MSG));
	endtask

	task automatic send_ack(bit [31:0] ak, bit good);
		gbn_pkg::in_word_t w;
		w = rand_word(gbn_pkg::CMD_ACK);
		w.ack_num = ak;
		w.check_in = board.checksum(w.seq_num, ak, w.payload_a, w.payload_b, w.payload_c);
		if (!good)
			w.check_in ^= 16'($urandom_range(1, 16'hFFFF));
		send_word(w);
	endtask

	task automatic send_good_ack();
		int n;
		n = board.outstanding();
		if (n == 0)
			send_ack(board.base - 1, 1'b1);
		else
			send_ack(board.base + $urandom_range(0, n - 1), 1'b1);
	endtask

	// result side: random ready, long holds on request
	initial begin
		int hold;
		int calm;
		hold = 0;
		calm = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready)
				board.check(out_ch.data);
			if (hold_req) begin
				hold_req = 1'b0;
				hold = 400;
			end
			if (calm == 0 && $urandom_range(0, 299) == 0)
				calm = $urandom_range(50, 200);
			if (hold > 0) begin
				hold--;
				out_ch.ready <= 1'b0;
			end else if (calm > 0) begin
				calm--;
				out_ch.ready <= 1'b1;
			end else if ($urandom_range(0, 99) < 2) begin
				hold = $urandom_range(10, 40);
				out_ch.ready <= 1'b0;
			end else
				out_ch.ready <= ($urandom_range(0, 9) < 7);
		end
	end

	initial begin
		#20_000_000;
		$display("go_back_n_sender_unit test failed");
		$finish;
	end

	initial begin
		gbn_pkg::in_word_t w;
		int r, wait_cycles;
		board = new();
		clk = 1'b0;
		arst_n = 1'b0;
		hold_req = 1'b0;
		no_gaps = 1'b0;
		sent_items = 0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed
		send_word(rand_word(gbn_pkg::CMD_TMO));
		send_word(rand_word(CMD_NONE));
		send_ack(32'd0, 1'b1);
		w = rand_word(gbn_pkg::CMD_MSG);
		w.payload_a = '0;
		w.payload_b = '0;
		w.payload_c = '0;
		send_word(w);
		w.payload_a = '1;
		w.payload_b = '1;
		w.payload_c = '1;
		send_word(w);
		repeat (5) send_msg();
		send_word(rand_word(gbn_pkg::CMD_TMO));
		send_ack(board.base, 1'b0);
		send_ack(board.nxt_unsent, 1'b1);
		send_ack(board.base - 1, 1'b1);
		send_ack(32'hFFFF_FFFF, 1'b1);
		send_ack(board.base + 1, 1'b1);
		send_word(rand_word(gbn_pkg::CMD_TMO));
		send_ack(board.nxt_unsent - 1, 1'b1);
		send_word(rand_word(gbn_pkg::CMD_ACK));
		send_word(rand_word(gbn_pkg::CMD_TMO));
		send_word(rand_word(CMD_NONE));

		// fill the queue while the receiver holds off
		hold_req = 1'b1;
		no_gaps = 1'b1;
		repeat (gbn_pkg::QUEUE_DEPTH + 4) send_msg();
		no_gaps = 1'b0;
		send_word(rand_word(gbn_pkg::CMD_TMO));

		// random mix
		while (sent_items < 300) begin
			if (sent_items % 100 == 0)
				no_gaps = ~no_gaps;
			r = $urandom_range(0, 99);
			if (r < 42)
				send_msg();
			else if (r < 72)
				send_good_ack();
			else if (r < 78)
				send_ack(board.base - 1 - $urandom_range(0, 3), 1'b1);
			else if (r < 84)
				send_word(rand_word(gbn_pkg::CMD_ACK));
			else if (r < 97)
				send_word(rand_word(gbn_pkg::CMD_TMO));
			else
				send_word(rand_word(CMD_NONE));
		end
		in_ch.valid <= 1'b0;

		wait_cycles = 0;
		while (board.expq.size() != 0 && wait_cycles < 20000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (60) @(posedge clk);
		if (board.mismatches == 0 && board.expq.size() == 0)
			$display("go_back_n_sender_unit test passed");
		else
			$display("go_back_n_sender_unit test failed");
		$finish;
	end
endmodule

// ===== files.f =====
hdl/gbn_pkg.sv
hdl/gbn_if.sv
hdl/go_back_n_sender_unit.sv
verif/tb.sv
